// ===== hw/rtl/b2f8_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b2f8_pkg: shared types and constants
// Format constants for the bfloat16 to fp8 (e4m3, bias 7) converter and the
// result bundle passed from the conversion core to the top level.
// ----------------------------------------------------------------------------
package b2f8_pkg;

   localparam int unsigned BF16_W = 16;
   localparam int unsigned FP8_W  = 8;

   localparam logic [7:0] BF16_EXP_SPECIAL = 8'hFF;
   localparam logic [7:0] EXP_ZERO_MAX     = 8'h74;  // at or below: flush to zero
   localparam logic [7:0] EXP_OVF_MIN      = 8'h87;  // at or above: infinity
   localparam logic [7:0] EXP_NORM_MIN     = 8'h79;  // smallest fp8 normal exponent
   localparam logic [7:0] EXP_REBIAS       = 8'd120; // 127 - 7
   localparam logic [7:0] SUB_SHIFT_BASE   = 8'd125; // shift = 125 - exp for subnormals
   localparam logic [3:0] NORM_SHIFT       = 4'd4;
   localparam logic [6:0] FP8_INF_MAG      = 7'h78;
   localparam logic [7:0] NAN_PATTERN_RST  = 8'h7C;

   typedef struct packed {
      logic [FP8_W-1:0] fp8;
      logic             inexact;
      logic             underflow;
      logic             overflow;
      logic             invalid;
   } b2f8_result_type;

endpackage : b2f8_pkg
`default_nettype wire

// ===== hw/rtl/b2f8_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b2f8_core: bfloat16 to fp8 conversion datapath
// Combinational: classifies the input, aligns and rounds the significand to
// nearest even, and builds the fp8 word with its exception flags.
// ----------------------------------------------------------------------------
module b2f8_core (
   input  wire logic [b2f8_pkg::BF16_W-1:0] bf16,
   input  wire logic [b2f8_pkg::FP8_W-1:0]  nan_pattern,
   output b2f8_pkg::b2f8_result_type        result
);
   import b2f8_pkg::*;

   logic        sgn;
   logic [7:0]  exp_b;
   logic [6:0]  frac;
   logic        is_normal_tgt;
   logic [7:0]  texp;
   logic [7:0]  sub_sh;
   logic [3:0]  sh;
   logic [15:0] aligned;
   logic [7:0]  kept;
   logic        round_bit;
   logic        sticky;
   logic        up;
   logic [6:0]  mag;
   logic        nx;

   assign sgn   = bf16[15];
   assign exp_b = bf16[14:7];
   assign frac  = bf16[6:0];

   always_comb begin
      is_normal_tgt = (exp_b >= EXP_NORM_MIN);
      texp          = exp_b - EXP_REBIAS;
      sub_sh        = SUB_SHIFT_BASE - exp_b;
      sh            = is_normal_tgt ? NORM_SHIFT : sub_sh[3:0];
      // significand with the hidden bit, guard bits below for round and sticky
      aligned       = {1'b1, frac, 8'h00} >> sh;
      kept          = aligned[15:8];
      round_bit     = aligned[7];
      sticky        = |aligned[6:0];
      up            = round_bit & (sticky | kept[0]);
      nx            = round_bit | sticky;
      if (is_normal_tgt) begin
         mag = {texp[3:0], kept[2:0]} + {6'd0, up};
      end else begin
         mag = kept[6:0] + {6'd0, up};
      end

      result = '0;
      if (exp_b == BF16_EXP_SPECIAL) begin
         if (frac != 7'd0) begin
            result.fp8     = nan_pattern;
            result.invalid = ~frac[6];
         end else begin
            result.fp8 = {sgn, FP8_INF_MAG};
         end
      end else if (exp_b == 8'd0 && frac == 7'd0) begin
         result.fp8 = {sgn, 7'd0};
      end else if (exp_b <= EXP_ZERO_MAX) begin
         result.fp8       = {sgn, 7'd0};
         result.inexact   = 1'b1;
         result.underflow = 1'b1;
      end else if (exp_b >= EXP_OVF_MIN || mag >= FP8_INF_MAG) begin
         result.fp8      = {sgn, FP8_INF_MAG};
         result.inexact  = 1'b1;
         result.overflow = 1'b1;
      end else begin
         result.fp8       = {sgn, mag};
         result.inexact   = nx;
         result.underflow = nx & ~is_normal_tgt;
      end
   end

endmodule : b2f8_core
`default_nettype wire

// ===== hw/rtl/bf16_to_fp8_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_to_fp8_converter_top: bfloat16 to fp8 e4m3 converter
// Input register, conversion core, result register; one csr for the NaN word.
// ----------------------------------------------------------------------------
// path: a req beat taken into the input register moves to the result register
//   once that register is free, and can leave on rsp from then on
// throughput: one beat per cycle; the conversion sits between the input and
//   result registers; under rsp_stall both stages fill and then req_stall rises
// reset: synchronous, clears both stage valids; nan pattern returns to 0x7C
// csr writes are always ready and take effect for the next converted beat
module bf16_to_fp8_converter_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [b2f8_pkg::BF16_W-1:0] req_bf16_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [b2f8_pkg::FP8_W-1:0]       rsp_fp8_out,
   output logic                             rsp_flag_inexact,
   output logic                             rsp_flag_underflow,
   output logic                             rsp_flag_overflow,
   output logic                             rsp_flag_invalid,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [b2f8_pkg::FP8_W-1:0]  csr_nan_pattern
);
   import b2f8_pkg::*;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [BF16_W-1:0]     s1_data_ff;
   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   b2f8_result_type       s2_data_ff;
   b2f8_result_type       conv;
   logic [FP8_W-1:0]      nan_pattern_ff;
   logic                  s2_free;
   logic                  req_take;
   logic                  s1_move;

   assign csr_ready = 1'b1;

   assign s2_free   = ~s2_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~s2_free;
   assign req_take  = req_valid & ~req_stall;
   assign s1_move   = s1_valid_ff & s2_free;

   assign s1_valid_in = req_take | (s1_valid_ff & ~s2_free);
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         nan_pattern_ff <= NAN_PATTERN_RST;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_valid && csr_ready) begin
            nan_pattern_ff <= csr_nan_pattern;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_bf16_in;
      end
      if (s1_move) begin
         s2_data_ff <= conv;
      end
   end

   b2f8_core u_core (
      .bf16        (s1_data_ff),
      .nan_pattern (nan_pattern_ff),
      .result      (conv)
   );

   assign rsp_valid          = s2_valid_ff;
   assign rsp_fp8_out        = s2_data_ff.fp8;
   assign rsp_flag_inexact   = s2_data_ff.inexact;
   assign rsp_flag_underflow = s2_data_ff.underflow;
   assign rsp_flag_overflow  = s2_data_ff.overflow;
   assign rsp_flag_invalid   = s2_data_ff.invalid;

   // overflow and underflow both imply a rounded result
   a_ovf_inexact : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_flag_overflow || rsp_flag_inexact))
      else $error("overflow without inexact");

   a_uf_inexact : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_flag_underflow || rsp_flag_inexact))
      else $error("underflow without inexact");

   a_invalid_alone : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag_invalid) |->
         (!rsp_flag_inexact && !rsp_flag_overflow && !rsp_flag_underflow))
      else $error("invalid raised with other flags");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_stall))
      else $error("req stalled with room in the pipeline");

   a_take_lands : assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted beat lost from input stage");

endmodule : bf16_to_fp8_converter_top
`default_nettype wire

// ===== tb/sv/tb_bf16_to_fp8_converter_top.sv =====
// ----------------------------------------------------------------------------
// tb_bf16_to_fp8_converter_top: bfloat16 to fp8 e4m3 converter testbench
// Walks a table of directed words, then random words under several nan
// pattern settings. Each accepted beat is predicted in the testbench and the
// results are compared field by field in order, with random pacing on both
// channels and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_bf16_to_fp8_converter_top;
   import b2f8_pkg::*;

   localparam int NUM_DIRECTED    = 24;
   localparam int NUM_PHASES      = 5;
   localparam int WORDS_PER_PHASE = 265;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;
   localparam logic CHK_TYPED     = 1'b1;
   localparam logic CHK_MODEL     = 1'b0;

   typedef struct packed {
      logic [BF16_W-1:0] word;
      logic              typed;
      b2f8_result_type   res;
   } stim_row_type;

   typedef struct packed {
      logic [BF16_W-1:0] word;
      b2f8_result_type   res;
   } pending_conv_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BF16_W-1:0] req_bf16_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [FP8_W-1:0]  rsp_fp8_out;
   logic              rsp_flag_inexact;
   logic              rsp_flag_underflow;
   logic              rsp_flag_overflow;
   logic              rsp_flag_invalid;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FP8_W-1:0]  csr_nan_pattern = '0;

   // side info travelling with the req beat, never seen by the block
   logic              req_typed = 1'b0;
   b2f8_result_type   req_typed_res = '0;

   logic [FP8_W-1:0]  nan_setting = NAN_PATTERN_RST;
   pending_conv_type  expected_conv_q [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                req_paced = 1'b1;
   bit                rsp_paced = 1'b1;
   bit                hold_off_request = 1'b0;

   // fp8 and flags: nx uf of nv
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      {16'h0000, CHK_TYPED, 8'h00, 4'b0000},           // positive zero
      {16'h8000, CHK_TYPED, 8'h80, 4'b0000},           // negative zero
      {16'h7F80, CHK_TYPED, 8'h78, 4'b0000},           // positive infinity
      {16'hFF80, CHK_TYPED, 8'hF8, 4'b0000},           // negative infinity
      {16'h7FC0, CHK_TYPED, NAN_PATTERN_RST, 4'b0000}, // quiet nan
      {16'hFF81, CHK_TYPED, NAN_PATTERN_RST, 4'b0001}, // signaling nan, negative
      {16'hFFFF, CHK_TYPED, NAN_PATTERN_RST, 4'b0000}, // quiet nan, all ones
      {16'h0001, CHK_TYPED, 8'h00, 4'b1100},           // bf16 subnormal
      {16'h807F, CHK_TYPED, 8'h80, 4'b1100},           // negative bf16 subnormal
      {16'h3A7F, CHK_TYPED, 8'h00, 4'b1100},           // top of flush range
      {16'h4380, CHK_TYPED, 8'h78, 4'b1010},           // bottom of overflow range
      {16'h7F7F, CHK_TYPED, 8'h78, 4'b1010},           // largest bf16 finite
      {16'hFF7F, CHK_TYPED, 8'hF8, 4'b1010},
      {16'h3F80, CHK_TYPED, 8'h38, 4'b0000},           // one
      {16'h3C80, CHK_TYPED, 8'h08, 4'b0000},           // smallest fp8 normal
      {16'h3A80, CHK_MODEL, 12'h000},                  // tie to zero in subnormal range
      {16'h3AC0, CHK_MODEL, 12'h000},
      {16'h437F, CHK_MODEL, 12'h000},                  // rounding carry into infinity
      {16'h4370, CHK_MODEL, 12'h000},                  // largest fp8 finite
      {16'h3F88, CHK_MODEL, 12'h000},                  // tie, stays even
      {16'h3F98, CHK_MODEL, 12'h000},                  // tie, rounds up to even
      {16'h3C7F, CHK_MODEL, 12'h000},                  // subnormal rounding up to normal
      {16'hBB40, CHK_MODEL, 12'h000},
      {16'hC0A5, CHK_MODEL, 12'h000}
   };

   bf16_to_fp8_converter_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bf16_in        (req_bf16_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fp8_out        (rsp_fp8_out),
      .rsp_flag_inexact   (rsp_flag_inexact),
      .rsp_flag_underflow (rsp_flag_underflow),
      .rsp_flag_overflow  (rsp_flag_overflow),
      .rsp_flag_invalid   (rsp_flag_invalid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_nan_pattern    (csr_nan_pattern)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic b2f8_result_type convert_bf16_to_e4m3(input logic [BF16_W-1:0] word,
                                                           input logic [FP8_W-1:0] nan_word);
      b2f8_result_type r;
      logic            sgn;
      int unsigned     ex, fr, sig, sh, kept, rem, half, mag;
      int              texp;
      logic            up;
      r   = '0;
      sgn = word[15];
      ex  = {24'd0, word[14:7]};
      fr  = {25'd0, word[6:0]};
      if (ex == BF16_EXP_SPECIAL) begin
         if (fr != 0) begin
            r.fp8     = nan_word;
            r.invalid = ~word[6];
         end else begin
            r.fp8 = {sgn, FP8_INF_MAG};
         end
      end else if (ex == 0 && fr == 0) begin
         r.fp8 = {sgn, 7'h00};
      end else if (ex <= EXP_ZERO_MAX) begin
         r.fp8       = {sgn, 7'h00};
         r.inexact   = 1'b1;
         r.underflow = 1'b1;
      end else if (ex >= EXP_OVF_MIN) begin
         r.fp8      = {sgn, FP8_INF_MAG};
         r.inexact  = 1'b1;
         r.overflow = 1'b1;
      end else begin
         texp = int'(ex) - 120;
         sig  = 128 + fr;
         sh   = (texp >= 1) ? 4 : 5 - texp;
         kept = sig >> sh;
         rem  = sig & ((1 << sh) - 1);
         half = 1 << (sh - 1);
         up   = (rem > half) || (rem == half && kept[0]);
         mag  = (texp >= 1) ? texp * 8 + (kept & 7) : kept;
         mag  = mag + up;
         if (mag >= FP8_INF_MAG) begin
            r.fp8      = {sgn, FP8_INF_MAG};
            r.inexact  = 1'b1;
            r.overflow = 1'b1;
         end else begin
            r.fp8       = {sgn, mag[6:0]};
            r.inexact   = (rem != 0);
            r.underflow = (texp <= 0) && (rem != 0);
         end
      end
      return r;
   endfunction

   // mostly the rounding window, with specials and the flush and overflow ranges mixed in
   function automatic logic [BF16_W-1:0] draw_bf16();
      logic [31:0] bits;
      logic [7:0]  ex;
      bits = $urandom;
      case ($urandom_range(0, 9))
         0: ex = BF16_EXP_SPECIAL;
         1: ex = 8'h00;
         2: ex = 8'($urandom_range(1, EXP_ZERO_MAX));
         3: ex = 8'($urandom_range(EXP_OVF_MIN, 8'hFE));
         4: ex = bits[23:16];
         default: ex = 8'($urandom_range(EXP_ZERO_MAX + 1, EXP_OVF_MIN - 1));
      endcase
      return {bits[15], ex, bits[6:0]};
   endfunction

   // called at a rising edge, returns at the edge where the beat is taken
   task automatic send_beat(input stim_row_type row);
      int gap;
      gap = req_paced ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bf16_in   <= row.word;
      req_typed     <= row.typed;
      req_typed_res <= row.res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one edge first so the beat taken at the current edge is already queued
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_conv_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_nan_pattern(input logic [FP8_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_nan_pattern <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      pending_conv_type want;
      b2f8_result_type  got;
      if (!reset) begin
         if (csr_valid && csr_ready) nan_setting <= csr_nan_pattern;
         if (req_valid && !req_stall) begin
            want.word = req_bf16_in;
            want.res  = req_typed ? req_typed_res
                                  : convert_bf16_to_e4m3(req_bf16_in, nan_setting);
            expected_conv_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_fp8_out, rsp_flag_inexact, rsp_flag_underflow,
                   rsp_flag_overflow, rsp_flag_invalid};
            if (expected_conv_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected rsp beat: fp8 %h flags %b", got.fp8, got[3:0]);
            end else begin
               want = expected_conv_q.pop_front();
               if (got.fp8 !== want.res.fp8 || got.inexact !== want.res.inexact ||
                   got.underflow !== want.res.underflow ||
                   got.overflow !== want.res.overflow ||
                   got.invalid !== want.res.invalid) begin
                  mismatch_count++;
                  // flags in the order nx uf of nv
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch bf16 %h: expected fp8 %h flags %b, got fp8 %h flags %b",
                              want.word, want.res.fp8, want.res[3:0],
                              got.fp8, got[3:0]);
               end
            end
         end
      end
   end

   // result side pacing, with the long hold-off counted here
   initial begin : rsp_pacing
      int stall_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            stall_cycles     = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall_cycles = rsp_paced ? $urandom_range(0, 13) : 0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      logic [FP8_W-1:0] nan_settings [NUM_PHASES];
      stim_row_type     row;
      nan_settings[0] = 8'h00;
      nan_settings[1] = 8'hFF;
      nan_settings[2] = 8'($urandom);
      nan_settings[3] = 8'($urandom);
      nan_settings[4] = 8'h7F;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) send_beat(directed_rows[i]);
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_nan_pattern(nan_settings[p]);
         // phase 1 runs flat out into a long stall; phase 4 pushes input back to back
         req_paced = (p != 1) && (p != 4);
         rsp_paced = (p != 1);
         if (p == 1) hold_off_request = 1'b1;
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            row = {draw_bf16(), CHK_MODEL, 12'h000};
            send_beat(row);
         end
      end
      wait_idle();
      if (mismatch_count == 0 && expected_conv_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/b2f8_pkg.sv
hw/rtl/b2f8_core.sv
hw/rtl/bf16_to_fp8_converter_top.sv
tb/sv/tb_bf16_to_fp8_converter_top.sv
